// File: design/dhbpwm_pkg.sv
`timescale 1ns / 1ps

package dhbpwm_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_SET_MODE = 2'd1,
    FUNC_DUTY_UP  = 2'd2,
    FUNC_DUTY_DN  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    MODE_STOP  = 3'd0,
    MODE_FWD   = 3'd1,
    MODE_BACK  = 3'd2,
    MODE_LEFT  = 3'd3,
    MODE_RIGHT = 3'd4,
    MODE_LSPIN = 3'd5,
    MODE_RSPIN = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    REG_PERIOD     = 2'd0,
    REG_DUTY_STEP  = 2'd1,
    REG_DUTY_FLOOR = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] period;
    logic [5:0] duty_step;
    logic [7:0] duty_floor;
  } cfg_t;

  // line bit order: left_ccw, left_cw, right_ccw, right_cw from bit 0 upwards
  localparam logic [3:0] LN_LCCW = 4'b0001;
  localparam logic [3:0] LN_LCW  = 4'b0010;
  localparam logic [3:0] LN_RCCW = 4'b0100;
  localparam logic [3:0] LN_RCW  = 4'b1000;
  localparam logic [3:0] LN_ALL  = 4'b1111;

  localparam logic [7:0] PERIOD_RST     = 8'd100;
  localparam logic [5:0] DUTY_STEP_RST  = 6'd5;
  localparam logic [7:0] DUTY_FLOOR_RST = 8'd10;
  localparam logic [7:0] DUTY_RST       = 8'd50;

endpackage

// File: design/dhbpwm_cfg_regs.sv
`timescale 1ns / 1ps

module dhbpwm_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [7:0]        cfg_wdata_i,
  output dhbpwm_pkg::cfg_t  cfg_o
);

  dhbpwm_pkg::cfg_t cfg_q;
  dhbpwm_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (dhbpwm_pkg::reg_idx_e'(cfg_idx_i))
        dhbpwm_pkg::REG_PERIOD:     cfg_d.period     = cfg_wdata_i;
        dhbpwm_pkg::REG_DUTY_STEP:  cfg_d.duty_step  = cfg_wdata_i[5:0];
        dhbpwm_pkg::REG_DUTY_FLOOR: cfg_d.duty_floor = cfg_wdata_i;
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period     <= dhbpwm_pkg::PERIOD_RST;
      cfg_q.duty_step  <= dhbpwm_pkg::DUTY_STEP_RST;
      cfg_q.duty_floor <= dhbpwm_pkg::DUTY_FLOOR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/dhbpwm_ctrl.sv
`timescale 1ns / 1ps

module dhbpwm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [1:0]        func_i,
  input  logic [2:0]        mode_i,
  input  dhbpwm_pkg::cfg_t  cfg_i,
  output logic [3:0]        lines_nxt_o,
  output logic [7:0]        duty_nxt_o
);

  logic [7:0]        phase_q, phase_d;
  logic [7:0]        duty_q, duty_d;
  dhbpwm_pkg::mode_e mode_q, mode_d;
  logic [3:0]        lines_q, lines_d;

  logic [7:0] phase_inc;
  logic       pwm_on;
  logic [3:0] pwm_set;
  logic [3:0] hi_fixed;
  logic [8:0] up_sum;
  logic [8:0] dn_diff;

  assign phase_inc = phase_q + 8'd1;
  assign pwm_on    = (phase_inc < duty_q);
  assign up_sum    = {1'b0, duty_q} + {3'b000, cfg_i.duty_step};
  assign dn_diff   = {1'b0, duty_q} - {3'b000, cfg_i.duty_step};

  always_comb begin
    hi_fixed = 4'b0000;
    case (mode_q)
      dhbpwm_pkg::MODE_FWD:   pwm_set = dhbpwm_pkg::LN_LCW | dhbpwm_pkg::LN_RCCW;
      dhbpwm_pkg::MODE_BACK:  pwm_set = dhbpwm_pkg::LN_LCCW | dhbpwm_pkg::LN_RCW;
      dhbpwm_pkg::MODE_LEFT: begin
        pwm_set  = dhbpwm_pkg::LN_RCCW;
        hi_fixed = dhbpwm_pkg::LN_LCCW | dhbpwm_pkg::LN_LCW;
      end
      dhbpwm_pkg::MODE_RIGHT: pwm_set = dhbpwm_pkg::LN_LCW;
      dhbpwm_pkg::MODE_LSPIN: pwm_set = dhbpwm_pkg::LN_LCCW | dhbpwm_pkg::LN_RCCW;
      default:                pwm_set = dhbpwm_pkg::LN_LCW | dhbpwm_pkg::LN_RCW;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    duty_d  = duty_q;
    mode_d  = mode_q;
    lines_d = lines_q;
    case (dhbpwm_pkg::func_e'(func_i))
      dhbpwm_pkg::FUNC_TICK: begin
        if (mode_q == dhbpwm_pkg::MODE_STOP) begin
          lines_d = dhbpwm_pkg::LN_ALL;
        end else begin
          lines_d = hi_fixed | (pwm_on ? pwm_set : 4'b0000);
          phase_d = (phase_inc >= cfg_i.period) ? 8'd0 : phase_inc;
        end
      end
      dhbpwm_pkg::FUNC_SET_MODE: begin
        if (mode_i <= dhbpwm_pkg::MODE_RSPIN) begin
          mode_d = dhbpwm_pkg::mode_e'(mode_i);
        end
      end
      dhbpwm_pkg::FUNC_DUTY_UP: begin
        duty_d = (up_sum >= {1'b0, cfg_i.period}) ? cfg_i.period : up_sum[7:0];
      end
      default: begin
        // saturate at the floor, borrow included
        duty_d = (dn_diff[8] || (dn_diff[7:0] <= cfg_i.duty_floor)) ?
                 cfg_i.duty_floor : dn_diff[7:0];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 8'd0;
      duty_q  <= dhbpwm_pkg::DUTY_RST;
      mode_q  <= dhbpwm_pkg::MODE_STOP;
      lines_q <= dhbpwm_pkg::LN_ALL;
    end else if (accept_i) begin
      phase_q <= phase_d;
      duty_q  <= duty_d;
      mode_q  <= mode_d;
      lines_q <= lines_d;
    end
  end

  assign lines_nxt_o = lines_d;
  assign duty_nxt_o  = duty_d;

endmodule

// File: design/dual_h_bridge_pwm_driver_core.sv
`timescale 1ns / 1ps
// Result valid in the cycle after the input transfer, by the single pass from state
// registers through the update logic to the result register. Throughput: one item per
// cycle unless out_ready_i stalls the output; the result register refills in the cycle it drains.
// Reset: control registers back to period 100, step 5, floor 10, duty 50, stop mode,
// counter 0, all gate lines high; the output line and duty registers are not reset; no result pending.

module dual_h_bridge_pwm_driver_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  input  logic [2:0] mode_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       left_ccw_o,
  output logic       left_cw_o,
  output logic       right_ccw_o,
  output logic       right_cw_o,
  output logic [7:0] duty_now_o
);

  dhbpwm_pkg::cfg_t cfg;
  logic             accept;
  logic [3:0]       lines_nxt;
  logic [7:0]       duty_nxt;
  logic             out_valid_q, out_valid_d;
  logic [3:0]       lines_q;
  logic [7:0]       duty_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  dhbpwm_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dhbpwm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (func_i),
    .mode_i      (mode_i),
    .cfg_i       (cfg),
    .lines_nxt_o (lines_nxt),
    .duty_nxt_o  (duty_nxt)
  );

  assign out_valid_d = accept || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lines_q <= lines_nxt;
      duty_q  <= duty_nxt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_ccw_o  = lines_q[0];
  assign left_cw_o   = lines_q[1];
  assign right_ccw_o = lines_q[2];
  assign right_cw_o  = lines_q[3];
  assign duty_now_o  = duty_q;

endmodule
